// ===== rtl/core/uv_exposure_channel_controller_unit_macros.svh =====
// Assertion macros shared by the exposure channel controller RTL
`ifndef UV_EXPOSURE_CHANNEL_CONTROLLER_UNIT_MACROS_SVH
`define UV_EXPOSURE_CHANNEL_CONTROLLER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define UVECC_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) else $error(msg);
`define UVECC_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);
`else
`define UVECC_ASSERT(lbl, clk_i, rstn_i, prop, msg)
`define UVECC_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons, msg)
`endif
`endif

// ===== rtl/core/uvecc_pkg.sv =====
// Types, codes and constants of the exposure channel controller
package uvecc_pkg;

	localparam int STAGE_COUNT      = 10;
	localparam int STAGE_W          = 4;
	localparam int LAMP_CHECK_DELAY = 3;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 16;

	localparam logic [STAGE_W:0]   STAGE_LIMIT = (STAGE_W + 1)'(STAGE_COUNT);
	localparam logic [STAGE_W-1:0] STAGE_LAST  = STAGE_W'(STAGE_COUNT - 1);
	localparam logic [15:0]        LAMP_DELAY  = 16'(LAMP_CHECK_DELAY);

	// hours = (total >> 4) * HOUR_RECIP >> HOUR_SHIFT, exact for 28-bit operands
	localparam logic [28:0] HOUR_RECIP   = 29'd305419897;
	localparam int          HOUR_SHIFT   = 36;
	localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
	// minutes = rem * MIN_RECIP >> MIN_SHIFT, exact for rem below one hour
	localparam logic [12:0] MIN_RECIP    = 13'd4370;
	localparam int          MIN_SHIFT    = 18;

	localparam logic [1:0] MODE_MANUAL  = 2'd0;
	localparam logic [1:0] MODE_FIXED   = 2'd1;
	localparam logic [1:0] MODE_PROFILE = 2'd2;
	localparam logic [1:0] MODE_SPARE   = 2'd3;

	localparam logic [1:0] CAUSE_NONE   = 2'd0;
	localparam logic [1:0] CAUSE_NORMAL = 2'd1;
	localparam logic [1:0] CAUSE_TEMP   = 2'd2;
	localparam logic [1:0] CAUSE_LAMP   = 2'd3;

	localparam logic FUNC_TICK        = 1'b0;
	localparam logic FUNC_STAGE_WRITE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_POWER = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALARM_TEMP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXPOSURE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_RELAY_DELAY = 3'd5;

	typedef struct packed {
		logic                  we;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] wdata;
	} uvecc_cfg_wr_t;

	typedef struct packed {
		logic               func;
		logic               trigger_level;
		logic               lamp_ok;
		logic [7:0]         temperature;
		logic               session_end;
		logic [STAGE_W-1:0] stage_index;
		logic [7:0]         stage_power;
		logic [15:0]        stage_seconds;
	} uvecc_in_t;

	typedef struct packed {
		logic               output_enable;
		logic [7:0]         drive_power;
		logic               relay_on;
		logic               alarm;
		logic               beep;
		logic               complete;
		logic [1:0]         stop_cause;
		logic [15:0]        time_shown;
		logic [20:0]        total_hours;
		logic [5:0]         total_minutes;
		logic [5:0]         total_secs;
		logic [STAGE_W-1:0] stage_now;
	} uvecc_out_t;

	// result of the channel update, before the on-time split
	typedef struct packed {
		logic               output_enable;
		logic [7:0]         drive_power;
		logic               relay_on;
		logic               alarm;
		logic               beep;
		logic               complete;
		logic [1:0]         stop_cause;
		logic [15:0]        time_shown;
		logic [STAGE_W-1:0] stage_now;
		logic [31:0]        on_time;
	} uvecc_raw_t;

endpackage

// ===== rtl/core/uvecc_core.sv =====
// Channel state update: input register, tick logic, stage tables, result register
`include "uv_exposure_channel_controller_unit_macros.svh"
module uvecc_core (
	input  logic                    clk,
	input  logic                    arst_n,
	input  uvecc_pkg::uvecc_cfg_wr_t cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  uvecc_pkg::uvecc_in_t    in_item,
	output logic                    out_valid,
	input  logic                    out_ready,
	output uvecc_pkg::uvecc_raw_t   out_raw
);
	import uvecc_pkg::*;

	// configuration
	logic [1:0]  mode_q;
	logic [7:0]  fixed_power_q;
	logic [7:0]  alarm_temp_q;
	logic [15:0] exposure_q;
	logic [7:0]  rounds_q;
	logic [7:0]  relay_delay_q;

	// channel state
	logic               running_q, was_running_q, last_trigger_q;
	logic               alarm_q, beep_q, complete_q, relay_q;
	logic [15:0]        elapsed_q;
	logic [STAGE_W-1:0] stage_q;
	logic [7:0]         round_q;
	logic [31:0]        on_time_q;
	logic [7:0]         relay_cnt_q;
	logic [15:0]        cur_time_q;
	logic [7:0]         pw_tab_q [STAGE_COUNT];
	logic [15:0]        tm_tab_q [STAGE_COUNT];

	// pipeline
	logic       v_s1, v_s2;
	uvecc_in_t  item_s1;
	uvecc_raw_t raw_s2;
	logic       en1, en2, upd;

	// next state
	logic               run, wr, lt, al, bf, cf, rs, tf, lf, tab_we;
	logic [15:0]        el, add_val;
	logic [STAGE_W-1:0] st;
	logic [7:0]         rnd, rc;
	logic [1:0]         cause;
	logic [32:0]        tot_sum;
	logic [31:0]        tot;
	logic [7:0]         rd_pw, pw;
	logic [15:0]        rd_tm, shown;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= MODE_MANUAL;
			fixed_power_q <= 8'd0;
			alarm_temp_q  <= 8'd80;
			exposure_q    <= 16'd10;
			rounds_q      <= 8'd1;
			relay_delay_q <= 8'd0;
		end else if (cfg.we) begin
			unique case (cfg.index)
				CFG_MODE:        mode_q        <= cfg.wdata[1:0];
				CFG_FIXED_POWER: fixed_power_q <= cfg.wdata[7:0];
				CFG_ALARM_TEMP:  alarm_temp_q  <= cfg.wdata[7:0];
				CFG_EXPOSURE:    exposure_q    <= cfg.wdata;
				CFG_ROUNDS:      rounds_q      <= cfg.wdata[7:0];
				CFG_RELAY_DELAY: relay_delay_q <= cfg.wdata[7:0];
				default: ;
			endcase
		end
	end

	assign en2      = !v_s2 || out_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign upd      = v_s1 && en2;

	always_comb begin
		run     = running_q;
		wr      = was_running_q;
		lt      = last_trigger_q;
		al      = alarm_q;
		bf      = beep_q;
		cf      = complete_q;
		rs      = relay_q;
		rc      = relay_cnt_q;
		el      = elapsed_q;
		st      = stage_q;
		rnd     = round_q;
		cause   = CAUSE_NONE;
		add_val = 16'd0;
		tab_we  = 1'b0;
		lf      = 1'b0;
		tf      = (item_s1.temperature >= alarm_temp_q) || (item_s1.temperature == 8'd0);
		if (item_s1.func == FUNC_STAGE_WRITE) begin
			tab_we = {1'b0, item_s1.stage_index} < STAGE_LIMIT;
		end else begin
			if (rc != 8'd0) begin
				rc = rc - 8'd1;
				if (rc == 8'd0) begin
					rs = 1'b0;
				end
			end
			if (item_s1.trigger_level != lt) begin
				if (!item_s1.trigger_level) begin
					if (mode_q == MODE_PROFILE) begin
						run = !run;
					end else if (mode_q == MODE_FIXED && run) begin
						el = 16'd0;
					end else begin
						run = 1'b1;
					end
				end else if (mode_q == MODE_MANUAL || mode_q == MODE_SPARE) begin
					run = 1'b0;
				end
				lt = item_s1.trigger_level;
			end
			if (run) begin
				if (!wr) begin
					el  = 16'd0;
					cf  = 1'b0;
					wr  = 1'b1;
					rs  = 1'b1;
					rc  = 8'd0;
					st  = '0;
					rnd = 8'd0;
				end
				lf = (el >= LAMP_DELAY) && !item_s1.lamp_ok;
				if (tf || lf) begin
					bf  = 1'b1;
					al  = 1'b1;
					run = 1'b0;
				end else begin
					bf = 1'b0;
				end
				if (el != 16'hFFFF) begin
					el = el + 16'd1;
				end
				if (mode_q == MODE_FIXED) begin
					if (el >= exposure_q) begin
						run = 1'b0;
						cf  = 1'b1;
					end
				end else if (mode_q == MODE_PROFILE) begin
					// a fresh start reads stage zero, else the cached current entry
					if (el >= ((was_running_q) ? cur_time_q : tm_tab_q[0])) begin
						add_val = el;
						el      = 16'd0;
						if (st == STAGE_LAST) begin
							if (rnd != 8'hFF) begin
								rnd = rnd + 8'd1;
							end
							if (rnd >= rounds_q) begin
								run = 1'b0;
							end
							st = '0;
						end else begin
							st = st + STAGE_W'(1);
						end
					end
				end
			end else if (wr) begin
				cause   = tf ? CAUSE_TEMP : (!item_s1.lamp_ok ? CAUSE_LAMP : CAUSE_NORMAL);
				wr      = 1'b0;
				rc      = relay_delay_q;
				rs      = relay_delay_q != 8'd0;
				add_val = el;
			end
			if (item_s1.session_end) begin
				if (wr) begin
					// at most one of the two additions is nonzero
					if (el != 16'd0) begin
						add_val = el;
					end
					if (cause == CAUSE_NONE) begin
						cause = CAUSE_NORMAL;
					end
				end
				wr  = 1'b0;
				run = 1'b0;
				al  = 1'b0;
				bf  = 1'b0;
				cf  = 1'b0;
				rc  = relay_delay_q;
				rs  = relay_delay_q != 8'd0;
			end
		end
		tot_sum = {1'b0, on_time_q} + 33'(add_val);
		tot     = tot_sum[32] ? 32'hFFFF_FFFF : tot_sum[31:0];
	end

	// single read of the stage tables at the resulting stage, write forwarded
	always_comb begin
		if (tab_we && item_s1.stage_index == st) begin
			rd_pw = item_s1.stage_power;
			rd_tm = item_s1.stage_seconds;
		end else begin
			rd_pw = pw_tab_q[st];
			rd_tm = tm_tab_q[st];
		end
		pw = (mode_q == MODE_PROFILE) ? rd_pw : fixed_power_q;
		if (mode_q == MODE_FIXED) begin
			shown = (exposure_q > el) ? exposure_q - el : 16'd0;
		end else if (mode_q == MODE_PROFILE) begin
			shown = (rd_tm > el) ? rd_tm - el : 16'd0;
		end else begin
			shown = el;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1           <= 1'b0;
			v_s2           <= 1'b0;
			running_q      <= 1'b0;
			was_running_q  <= 1'b0;
			last_trigger_q <= 1'b1;
			alarm_q        <= 1'b0;
			beep_q         <= 1'b0;
			complete_q     <= 1'b0;
			relay_q        <= 1'b0;
			relay_cnt_q    <= 8'd0;
			elapsed_q      <= 16'd0;
			stage_q        <= '0;
			round_q        <= 8'd0;
			on_time_q      <= 32'd0;
			cur_time_q     <= 16'd0;
			for (int i = 0; i < STAGE_COUNT; i++) begin
				pw_tab_q[i] <= 8'd0;
				tm_tab_q[i] <= 16'd0;
			end
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (upd) begin
				running_q      <= run;
				was_running_q  <= wr;
				last_trigger_q <= lt;
				alarm_q        <= al;
				beep_q         <= bf;
				complete_q     <= cf;
				relay_q        <= rs;
				relay_cnt_q    <= rc;
				elapsed_q      <= el;
				stage_q        <= st;
				round_q        <= rnd;
				on_time_q      <= tot;
				cur_time_q     <= rd_tm;
				if (tab_we) begin
					pw_tab_q[item_s1.stage_index] <= item_s1.stage_power;
					tm_tab_q[item_s1.stage_index] <= item_s1.stage_seconds;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			item_s1 <= in_item;
		end
		if (upd) begin
			raw_s2.output_enable <= wr;
			raw_s2.drive_power   <= wr ? pw : 8'd0;
			raw_s2.relay_on      <= rs;
			raw_s2.alarm         <= al;
			raw_s2.beep          <= bf;
			raw_s2.complete      <= cf;
			raw_s2.stop_cause    <= cause;
			raw_s2.time_shown    <= shown;
			raw_s2.stage_now     <= st;
			raw_s2.on_time       <= tot;
		end
	end

	assign out_valid = v_s2;
	assign out_raw   = raw_s2;

	`UVECC_ASSERT(a_stage_range, clk, arst_n, {1'b0, stage_q} < STAGE_LIMIT, "stage out of range")
	`UVECC_ASSERT_IMP(a_cnt_relay, clk, arst_n, relay_cnt_q != 8'd0, relay_q, "countdown without relay")
	`UVECC_ASSERT_IMP(a_run_relay, clk, arst_n, was_running_q, relay_q, "driver on, relay off")
	`UVECC_ASSERT(a_cur_cache, clk, arst_n, cur_time_q == tm_tab_q[stage_q], "stage time cache stale")
endmodule

// ===== rtl/core/uvecc_time_split.sv =====
// On-time split into hours, minutes and seconds over three pipeline stages
`include "uv_exposure_channel_controller_unit_macros.svh"
module uvecc_time_split (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  uvecc_pkg::uvecc_raw_t in_raw,
	output logic                  out_valid,
	input  logic                  out_ready,
	output uvecc_pkg::uvecc_out_t out_item
);
	import uvecc_pkg::*;

	logic       v_s3, v_s4, v_s5;
	logic       en3, en4, en5;
	uvecc_raw_t raw_s3, raw_s4, raw_s5;
	logic [20:0] hours_s3, hours_s4, hours_s5;
	logic [11:0] rem_s4;
	logic [5:0]  min_s5, sec_s5;

	logic [56:0] hour_prod;
	logic [32:0] hour_secs;
	logic [31:0] rem_full;
	logic [24:0] min_prod;
	logic [5:0]  min_val;
	logic [11:0] min_secs, sec_full;

	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign in_ready = en3;

	assign hour_prod = 57'(in_raw.on_time[31:4]) * 57'(HOUR_RECIP);
	assign hour_secs = 33'(hours_s3) * 33'(SEC_PER_HOUR);
	assign rem_full  = raw_s3.on_time - hour_secs[31:0];
	assign min_prod  = 25'(rem_s4) * 25'(MIN_RECIP);
	assign min_val   = min_prod[MIN_SHIFT+5:MIN_SHIFT];
	// times sixty as 64x - 4x
	assign min_secs  = {min_val, 6'd0} - {4'd0, min_val, 2'd0};
	assign sec_full  = rem_s4 - min_secs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en3) begin
				v_s3 <= in_valid;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
			if (en5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && in_valid) begin
			raw_s3   <= in_raw;
			hours_s3 <= hour_prod[HOUR_SHIFT+20:HOUR_SHIFT];
		end
		if (en4 && v_s3) begin
			raw_s4   <= raw_s3;
			hours_s4 <= hours_s3;
			rem_s4   <= rem_full[11:0];
		end
		if (en5 && v_s4) begin
			raw_s5   <= raw_s4;
			hours_s5 <= hours_s4;
			min_s5   <= min_val;
			sec_s5   <= sec_full[5:0];
		end
	end

	assign out_valid = v_s5;
	always_comb begin
		out_item.output_enable = raw_s5.output_enable;
		out_item.drive_power   = raw_s5.drive_power;
		out_item.relay_on      = raw_s5.relay_on;
		out_item.alarm         = raw_s5.alarm;
		out_item.beep          = raw_s5.beep;
		out_item.complete      = raw_s5.complete;
		out_item.stop_cause    = raw_s5.stop_cause;
		out_item.time_shown    = raw_s5.time_shown;
		out_item.total_hours   = hours_s5;
		out_item.total_minutes = min_s5;
		out_item.total_secs    = sec_s5;
		out_item.stage_now     = raw_s5.stage_now;
	end

	`UVECC_ASSERT(a_take_s3, clk, arst_n, in_valid && in_ready |=> v_s3, "accepted item lost")
	`UVECC_ASSERT_IMP(a_rem_hour, clk, arst_n, v_s4, rem_s4 < SEC_PER_HOUR, "remainder over an hour")
	`UVECC_ASSERT_IMP(a_min_sec, clk, arst_n, v_s5, min_s5 < 6'd60 && sec_s5 < 6'd60,
		"minutes or seconds out of range")
endmodule

// ===== rtl/core/uv_exposure_channel_controller_unit.sv =====
// Top level of one exposure lamp channel controller
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------
//   in       | in_valid / in_ready  | in_item  (uvecc_in_t)
//   out      | out_valid / out_ready| out_item (uvecc_out_t)
//   cfg      | cfg_we               | cfg_index, cfg_wdata
//
// One item per cycle sustained while out_ready is high; a taken item passes the input
// register, the channel update, then three stages for the on-time split
// (reciprocal multiply for hours, remainder, minutes and seconds).
// arst_n clears all channel state and the stage tables at once; no clearing pass.
// With out_ready low the pipeline holds and in_ready drops once all stages are full.
module uv_exposure_channel_controller_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  uvecc_pkg::uvecc_in_t                 in_item,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output uvecc_pkg::uvecc_out_t                out_item,
	input  logic                                 cfg_we,
	input  logic [uvecc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [uvecc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import uvecc_pkg::*;

	uvecc_cfg_wr_t cfg;
	uvecc_raw_t    raw;
	logic          raw_valid, raw_ready;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.wdata = cfg_wdata;

	uvecc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (raw_valid),
		.out_ready (raw_ready),
		.out_raw   (raw)
	);

	uvecc_time_split u_split (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (raw_valid),
		.in_ready  (raw_ready),
		.in_raw    (raw),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);
endmodule

// ===== bench/uv_exposure_channel_controller_unit_test.sv =====
// Self-checking bench for the exposure channel controller: random and directed items vs a local model
module uv_exposure_channel_controller_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import uvecc_pkg::*;

	localparam int CLK_PERIOD      = 12;
	localparam int RESET_CYCLES    = 9;
	localparam int PIPE_SETTLE     = 10;
	localparam int CYCLE_LIMIT     = 300000;
	localparam int IDLE_PCT        = 21;
	localparam int HOLD_OFF_AT     = 250;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int PHASE_ITEMS     = 52;
	localparam int PHASE_COUNT     = 8;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	uvecc_in_t             in_item   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	uvecc_out_t            out_item;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	uv_exposure_channel_controller_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// register copies
	logic [1:0]  reg_mode        = MODE_MANUAL;
	logic [7:0]  reg_power       = 8'd0;
	logic [7:0]  reg_alarm_temp  = 8'd80;
	logic [15:0] reg_exposure    = 16'd10;
	logic [7:0]  reg_rounds      = 8'd1;
	logic [7:0]  reg_relay_delay = 8'd0;

	// channel state of the model
	logic               ch_running     = 1'b0;
	logic               ch_driver_on   = 1'b0;
	logic               ch_last_trig   = 1'b1;
	logic               ch_alarm       = 1'b0;
	logic               ch_beep        = 1'b0;
	logic               ch_complete    = 1'b0;
	logic               ch_relay       = 1'b0;
	logic [15:0]        ch_elapsed     = 16'd0;
	logic [STAGE_W-1:0] ch_stage       = '0;
	logic [7:0]         ch_rounds_done = 8'd0;
	logic [31:0]        ch_on_time     = 32'd0;
	logic [7:0]         ch_relay_left  = 8'd0;
	logic [7:0]         ch_stage_power [STAGE_COUNT];
	logic [15:0]        ch_stage_time  [STAGE_COUNT];

	uvecc_in_t  pending_items [$];
	uvecc_out_t status_due    [$];
	int         items_queued  = 0;
	int         items_taken   = 0;
	int         results_seen  = 0;
	int         errors        = 0;
	int         cycles        = 0;
	int         hold_left     = 0;
	logic       hold_done     = 1'b0;
	logic       steady        = 1'b0;
	logic       trig_now      = 1'b1;

	initial begin
		for (int i = 0; i < STAGE_COUNT; i++) begin
			ch_stage_power[i] = 8'd0;
			ch_stage_time[i]  = 16'd0;
		end
	end

	function automatic logic [15:0] secs_left(logic [15:0] target);
		return (target > ch_elapsed) ? target - ch_elapsed : 16'd0;
	endfunction

	function automatic void add_on_time(logic [31:0] secs);
		logic [32:0] sum;
		sum = {1'b0, ch_on_time} + {1'b0, secs};
		ch_on_time = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	endfunction

	function automatic void release_relay();
		ch_relay_left = reg_relay_delay;
		ch_relay      = (reg_relay_delay != 8'd0);
	endfunction

	function automatic uvecc_out_t channel_status(logic [1:0] cause);
		uvecc_out_t         s;
		logic [STAGE_W-1:0] st;
		logic [7:0]         pw;
		st = (ch_stage < STAGE_COUNT) ? ch_stage : '0;
		pw = (reg_mode == MODE_PROFILE) ? ch_stage_power[st] : reg_power;
		s.output_enable = ch_driver_on;
		s.drive_power   = ch_driver_on ? pw : 8'd0;
		s.relay_on      = ch_relay;
		s.alarm         = ch_alarm;
		s.beep          = ch_beep;
		s.complete      = ch_complete;
		s.stop_cause    = cause;
		if (reg_mode == MODE_FIXED) begin
			s.time_shown = secs_left(reg_exposure);
		end else if (reg_mode == MODE_PROFILE) begin
			s.time_shown = secs_left(ch_stage_time[st]);
		end else begin
			s.time_shown = ch_elapsed;
		end
		s.total_hours   = 21'(ch_on_time / 32'd3600);
		s.total_minutes = 6'((ch_on_time % 32'd3600) / 32'd60);
		s.total_secs    = 6'(ch_on_time % 32'd60);
		s.stage_now     = st;
		return s;
	endfunction

	// one item through the channel; returns the status it should produce
	function automatic uvecc_out_t advance_channel(uvecc_in_t it);
		logic [1:0]         cause;
		logic               temp_trip;
		logic               lamp_trip;
		logic [STAGE_W-1:0] st;
		cause = CAUSE_NONE;
		if (it.func == FUNC_STAGE_WRITE) begin
			if (it.stage_index < STAGE_COUNT) begin
				ch_stage_power[it.stage_index] = it.stage_power;
				ch_stage_time[it.stage_index]  = it.stage_seconds;
			end
			return channel_status(CAUSE_NONE);
		end

		if (ch_relay_left != 8'd0) begin
			ch_relay_left--;
			if (ch_relay_left == 8'd0) ch_relay = 1'b0;
		end

		if (it.trigger_level != ch_last_trig) begin
			if (!it.trigger_level) begin
				if (reg_mode == MODE_PROFILE) ch_running = !ch_running;
				else if (reg_mode == MODE_FIXED && ch_running) ch_elapsed = 16'd0;
				else ch_running = 1'b1;
			end else if (reg_mode == MODE_MANUAL || reg_mode == MODE_SPARE) begin
				ch_running = 1'b0;
			end
			ch_last_trig = it.trigger_level;
		end

		temp_trip = (it.temperature >= reg_alarm_temp) || (it.temperature == 8'd0);

		if (ch_running) begin
			if (!ch_driver_on) begin
				ch_elapsed     = 16'd0;
				ch_complete    = 1'b0;
				ch_driver_on   = 1'b1;
				ch_relay       = 1'b1;
				ch_relay_left  = 8'd0;
				ch_stage       = '0;
				ch_rounds_done = 8'd0;
			end
			lamp_trip = (ch_elapsed >= LAMP_DELAY) && !it.lamp_ok;
			if (temp_trip || lamp_trip) begin
				ch_beep    = 1'b1;
				ch_alarm   = 1'b1;
				ch_running = 1'b0;
			end else begin
				ch_beep = 1'b0;
			end
			if (ch_elapsed != 16'hFFFF) ch_elapsed++;
			if (reg_mode == MODE_FIXED) begin
				if (ch_elapsed >= reg_exposure) begin
					ch_running  = 1'b0;
					ch_complete = 1'b1;
				end
			end else if (reg_mode == MODE_PROFILE) begin
				st = (ch_stage < STAGE_COUNT) ? ch_stage : '0;
				if (ch_elapsed >= ch_stage_time[st]) begin
					add_on_time(32'(ch_elapsed));
					ch_elapsed = 16'd0;
					// wrap after the last stage and count the round
					if (st == STAGE_LAST) begin
						if (ch_rounds_done != 8'hFF) ch_rounds_done++;
						if (ch_rounds_done >= reg_rounds) ch_running = 1'b0;
						st = '0;
					end else begin
						st++;
					end
					ch_stage = st;
				end
			end
		end else if (ch_driver_on) begin
			cause = temp_trip ? CAUSE_TEMP : (!it.lamp_ok ? CAUSE_LAMP : CAUSE_NORMAL);
			ch_driver_on = 1'b0;
			release_relay();
			add_on_time(32'(ch_elapsed));
		end

		if (it.session_end) begin
			if (ch_driver_on) begin
				add_on_time(32'(ch_elapsed));
				if (cause == CAUSE_NONE) cause = CAUSE_NORMAL;
			end
			ch_driver_on = 1'b0;
			ch_running   = 1'b0;
			ch_alarm     = 1'b0;
			ch_beep      = 1'b0;
			ch_complete  = 1'b0;
			release_relay();
		end
		return channel_status(cause);
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
			errors++;
		end
	endtask

	task automatic compare_status(input uvecc_out_t want, input uvecc_out_t got);
		check_field("output_enable", 32'(want.output_enable), 32'(got.output_enable));
		check_field("drive_power",   32'(want.drive_power),   32'(got.drive_power));
		check_field("relay_on",      32'(want.relay_on),      32'(got.relay_on));
		check_field("alarm",         32'(want.alarm),         32'(got.alarm));
		check_field("beep",          32'(want.beep),          32'(got.beep));
		check_field("complete",      32'(want.complete),      32'(got.complete));
		check_field("stop_cause",    32'(want.stop_cause),    32'(got.stop_cause));
		check_field("time_shown",    32'(want.time_shown),    32'(got.time_shown));
		check_field("total_hours",   32'(want.total_hours),   32'(got.total_hours));
		check_field("total_minutes", 32'(want.total_minutes), 32'(got.total_minutes));
		check_field("total_secs",    32'(want.total_secs),    32'(got.total_secs));
		check_field("stage_now",     32'(want.stage_now),     32'(got.stage_now));
	endtask

	// driver: offer items from the pending queue, predict at acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				status_due.push_back(advance_channel(in_item));
				items_taken++;
			end
			if (!in_valid || in_ready) begin
				if (pending_items.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
					in_item  <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: check results, pace out_ready, one long hold-off
	always @(posedge clk) begin
		uvecc_out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (status_due.size() == 0) begin
					$display("%0t: result with nothing expected, actual %h", $realtime, out_item);
					errors++;
				end else begin
					want = status_due.pop_front();
					compare_status(want, out_item);
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (!hold_done && results_seen >= HOLD_OFF_AT
					&& pending_items.size() > 20) begin
				hold_done = 1'b1;
				hold_left = HOLD_OFF_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $realtime, cycles);
			$display("status: fail");
			$finish;
		end
	end

	task automatic push_item(input uvecc_in_t it);
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic tick(input logic trig, input logic lamp, input logic [7:0] temp,
			input logic send);
		uvecc_in_t it;
		it = uvecc_in_t'({$urandom, $urandom});
		it.func          = FUNC_TICK;
		it.trigger_level = trig;
		it.lamp_ok       = lamp;
		it.temperature   = temp;
		it.session_end   = send;
		trig_now = trig;
		push_item(it);
	endtask

	task automatic stage_write(input logic [STAGE_W-1:0] idx, input logic [7:0] pw,
			input logic [15:0] secs);
		uvecc_in_t it;
		it = uvecc_in_t'({$urandom, $urandom});
		it.func          = FUNC_STAGE_WRITE;
		it.stage_index   = idx;
		it.stage_power   = pw;
		it.stage_seconds = secs;
		push_item(it);
	endtask

	// wait until every item is taken and every result has come back
	task automatic drain();
		while (items_taken != items_queued || status_due.size() != 0) @(posedge clk);
		repeat (PIPE_SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			CFG_MODE:        reg_mode        = data[1:0];
			CFG_FIXED_POWER: reg_power       = data[7:0];
			CFG_ALARM_TEMP:  reg_alarm_temp  = data[7:0];
			CFG_EXPOSURE:    reg_exposure    = data;
			CFG_ROUNDS:      reg_rounds      = data[7:0];
			CFG_RELAY_DELAY: reg_relay_delay = data[7:0];
			default: ;
		endcase
	endtask

	task automatic set_registers(input logic [1:0] mode, input logic [7:0] power,
			input logic [7:0] alarm_temp, input logic [15:0] exposure,
			input logic [7:0] rounds, input logic [7:0] relay_delay);
		drain();
		write_reg(CFG_MODE, 16'(mode));
		write_reg(CFG_FIXED_POWER, 16'(power));
		write_reg(CFG_ALARM_TEMP, 16'(alarm_temp));
		write_reg(CFG_EXPOSURE, exposure);
		write_reg(CFG_ROUNDS, 16'(rounds));
		write_reg(CFG_RELAY_DELAY, 16'(relay_delay));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly plausible ticks (held trigger, lit lamp, sane temperature), some stage writes
	task automatic random_item();
		logic [7:0] temp;
		if ($urandom_range(99) < 7) begin
			stage_write(STAGE_W'($urandom_range(15)), 8'($urandom),
				($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(5)));
		end else begin
			if ($urandom_range(5) == 0) trig_now = !trig_now;
			if ($urandom_range(24) == 0) begin
				temp = $urandom_range(1) ? 8'd0 : 8'($urandom_range(255, reg_alarm_temp));
			end else if (reg_alarm_temp > 8'd1) begin
				temp = 8'($urandom_range(reg_alarm_temp - 1, 1));
			end else begin
				temp = 8'($urandom);
			end
			tick(trig_now, $urandom_range(19) != 0, temp, $urandom_range(39) == 0);
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// manual mode: table writes, lamp fault, temperature trip, session end
		set_registers(MODE_MANUAL, 8'd255, 8'd80, 16'd10, 8'd1, 8'd2);
		stage_write(4'd0, 8'd255, 16'hFFFF);
		stage_write(4'd9, 8'd0, 16'd0);
		stage_write(4'd15, 8'hAA, 16'h5555);
		stage_write(4'd10, 8'h55, 16'hAAAA);
		tick(1'b1, 1'b1, 8'd25, 1'b0);
		tick(1'b0, 1'b1, 8'd25, 1'b0);
		tick(1'b0, 1'b1, 8'd79, 1'b0);
		tick(1'b0, 1'b1, 8'd1, 1'b0);
		tick(1'b0, 1'b0, 8'd25, 1'b0);
		tick(1'b0, 1'b0, 8'd25, 1'b0);
		tick(1'b1, 1'b1, 8'd25, 1'b0);
		tick(1'b0, 1'b1, 8'd0, 1'b0);
		tick(1'b0, 1'b1, 8'd255, 1'b0);
		tick(1'b1, 1'b1, 8'd25, 1'b1);
		tick(1'b0, 1'b1, 8'd30, 1'b0);
		tick(1'b0, 1'b1, 8'd30, 1'b1);
		tick(1'b1, 1'b1, 8'd80, 1'b0);

		// fixed time: run to completion, then restart on a repeat edge
		set_registers(MODE_FIXED, 8'd0, 8'd255, 16'd2, 8'd0, 8'd0);
		tick(1'b0, 1'b1, 8'd254, 1'b0);
		tick(1'b0, 1'b1, 8'd254, 1'b0);
		tick(1'b0, 1'b1, 8'd254, 1'b0);
		tick(1'b1, 1'b1, 8'd254, 1'b0);
		tick(1'b0, 1'b1, 8'd254, 1'b0);
		tick(1'b1, 1'b1, 8'd254, 1'b0);
		tick(1'b0, 1'b1, 8'd254, 1'b0);
		tick(1'b0, 1'b1, 8'd254, 1'b0);

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: set_registers(MODE_PROFILE, 8'($urandom), 8'd200,
					16'($urandom_range(20, 1)), 8'd1, 8'd0);
				1: set_registers(MODE_FIXED, 8'd255, 8'd255, 16'd0, 8'd0, 8'd255);
				2: set_registers(MODE_MANUAL, 8'd0, 8'd0, 16'hFFFF, 8'd255, 8'd1);
				3: set_registers(MODE_SPARE, 8'($urandom), 8'($urandom_range(255, 100)),
					16'($urandom), 8'($urandom), 8'($urandom_range(4)));
				4: set_registers(MODE_PROFILE, 8'($urandom), 8'd150, 16'($urandom), 8'd0,
					8'($urandom_range(3, 1)));
				5: set_registers(MODE_FIXED, 8'($urandom), 8'd120, 16'hFFFF, 8'd2, 8'd3);
				6: set_registers(MODE_PROFILE, 8'($urandom), 8'($urandom_range(255, 60)),
					16'($urandom), 8'd3, 8'($urandom_range(5)));
				default: set_registers(MODE_MANUAL, 8'd255, 8'd90, 16'($urandom_range(20)),
					8'd1, 8'd0);
			endcase
			steady = (ph == 0);
			if (reg_mode == MODE_PROFILE) begin
				for (int s = 0; s < STAGE_COUNT; s++) begin
					stage_write(STAGE_W'(s), 8'($urandom),
						($urandom_range(9) == 0) ? 16'($urandom_range(40)) : 16'($urandom_range(4)));
				end
			end
			for (int n = 0; n < PHASE_ITEMS; n++) random_item();
			drain();
			steady = 1'b0;
		end

		drain();
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/uvecc_pkg.sv
rtl/core/uvecc_core.sv
rtl/core/uvecc_time_split.sv
rtl/core/uv_exposure_channel_controller_unit.sv
bench/uv_exposure_channel_controller_unit_test.sv
